/* rtl/core/lpf_pkg.sv */
// Shared types, constants and ring helpers for the length-prefixed packet FIFO.
// No dependencies; every other file of the block imports this package.
package lpf_pkg;

    localparam int STORE_BYTES  = 256;
    localparam int MAX_TELEGRAM = 32;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;

    localparam int ADDR_W     = $clog2(STORE_BYTES);
    localparam int USED_W     = $clog2(STORE_BYTES + 1);
    localparam int TLEN_W     = $clog2(MAX_TELEGRAM + 1);
    localparam int SUM_W      = $clog2(STORE_BYTES + (2 ** LEN_W) + 1);
    localparam int RING_WRAPS = (MAX_TELEGRAM + 1) / STORE_BYTES + 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_W     = $clog2(Q_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_POP_OK    = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_PROTOCOL  = 3'd5
    } t_status;

    typedef struct packed {
        t_cmd              command;
        logic [LEN_W-1:0]  telegram_length;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] max_size;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  popped_length;
        logic              last;
    } t_out_item;

    typedef struct packed {
        t_status           status;
        logic              stream;
        logic [ADDR_W-1:0] start;
        logic [TLEN_W-1:0] tlen;
    } t_job;

    typedef struct packed {
        logic q_full;
        logic q_empty;
        logic back_busy;
    } t_hold;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr_req;

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(STORE_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] p,
                                                   input logic [TLEN_W:0]   n);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(n);
        for (int k = 0; k < RING_WRAPS; k++) begin
            if (s >= SUM_W'(STORE_BYTES)) begin
                s = s - SUM_W'(STORE_BYTES);
            end
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/core/lpf_store.sv */
// Byte store of the packet FIFO: one write port, two registered read ports.
// Depends on lpf_pkg.
module lpf_store (
    input  logic                         i_clk,
    input  lpf_pkg::t_wr_req             i_wr,
    input  logic                         i_ra_en,
    input  logic [lpf_pkg::ADDR_W-1:0]   i_ra_addr,
    output logic [lpf_pkg::BYTE_W-1:0]   o_ra_data,
    input  logic                         i_rb_en,
    input  logic [lpf_pkg::ADDR_W-1:0]   i_rb_addr,
    output logic [lpf_pkg::BYTE_W-1:0]   o_rb_data
);
    import lpf_pkg::*;

    logic [BYTE_W-1:0] r_mem [STORE_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ra_en) begin
            o_ra_data <= r_mem[i_ra_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rb_en) begin
            o_rb_data <= r_mem[i_rb_addr];
        end
    end

endmodule

/* rtl/core/lpf_front.sv */
// Front part: accepts commands, keeps ring pointers and byte accounting,
// writes the store and queues one job per result-producing command. Uses lpf_pkg.
module lpf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  lpf_pkg::t_in_item            i_in_item,
    input  lpf_pkg::t_hold               i_hold,
    output lpf_pkg::t_job                o_job,
    output logic                         o_job_push,
    output lpf_pkg::t_wr_req             o_wr,
    output logic                         o_ra_en,
    output logic [lpf_pkg::ADDR_W-1:0]   o_ra_addr,
    input  logic [lpf_pkg::BYTE_W-1:0]   i_ra_data
);
    import lpf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LEN  = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_rd, n_rd;
    logic [ADDR_W-1:0]  r_wp, n_wp;
    logic [ADDR_W-1:0]  r_ce, n_ce;
    logic [USED_W-1:0]  r_used, n_used;
    logic [LEN_W-1:0]   r_owed, n_owed;
    logic [BYTE_W-1:0]  r_max;

    logic               is_begin, is_push, is_pop;
    logic               accept, empty, fits;
    logic [SUM_W-1:0]   need;
    logic [TLEN_W-1:0]  tlen;
    logic [TLEN_W:0]    span;
    logic [ADDR_W-1:0]  wp_next;

    always_comb begin
        is_begin = (i_in_item.command == CMD_BEGIN);
        is_push  = (i_in_item.command == CMD_PUSH);
        is_pop   = (i_in_item.command == CMD_POP);

        o_in_stall = (r_state != S_IDLE)
                   || ((is_begin || is_pop) && i_hold.q_full)
                   || ((is_begin || is_push) && (!i_hold.q_empty || i_hold.back_busy));
        accept = i_in_valid && !o_in_stall;

        empty = (r_rd == r_ce) && ((r_owed != '0) || (r_used == '0));
        need  = SUM_W'(r_used) + SUM_W'(i_in_item.telegram_length) + SUM_W'(1);
        fits  = (SUM_W'(i_in_item.telegram_length) <= SUM_W'(MAX_TELEGRAM))
              && (need <= SUM_W'(STORE_BYTES));

        tlen = (i_ra_data > BYTE_W'(MAX_TELEGRAM)) ? TLEN_W'(MAX_TELEGRAM)
                                                   : i_ra_data[TLEN_W-1:0];
        span    = (TLEN_W + 1)'(tlen) + 1'b1;
        wp_next = ring_next(r_wp);

        n_state    = r_state;
        n_rd       = r_rd;
        n_wp       = r_wp;
        n_ce       = r_ce;
        n_used     = r_used;
        n_owed     = r_owed;
        o_job      = '0;
        o_job_push = 1'b0;
        o_wr.we    = 1'b0;
        o_wr.addr  = r_wp;
        o_wr.data  = i_in_item.data_byte;
        o_ra_en    = 1'b0;
        o_ra_addr  = r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_item.command)
                        CMD_BEGIN: begin
                            o_job_push = 1'b1;
                            priority if (r_owed != '0) begin
                                o_job.status = ST_PROTOCOL;
                            end else if (!fits) begin
                                o_job.status = ST_FULL;
                            end else begin
                                o_job.status = ST_ACCEPTED;
                                o_wr.we   = 1'b1;
                                o_wr.data = BYTE_W'(i_in_item.telegram_length);
                                n_wp      = wp_next;
                                n_used    = r_used + USED_W'(i_in_item.telegram_length)
                                          + USED_W'(1);
                                n_owed    = i_in_item.telegram_length;
                                if (i_in_item.telegram_length == '0) begin
                                    n_ce = wp_next;
                                end
                            end
                        end
                        CMD_PUSH: begin
                            if (r_owed != '0) begin
                                o_wr.we = 1'b1;
                                n_wp    = wp_next;
                                n_owed  = r_owed - 1'b1;
                                if (r_owed == LEN_W'(1)) begin
                                    n_ce = wp_next;
                                end
                            end
                        end
                        CMD_POP: begin
                            if (empty) begin
                                o_job_push   = 1'b1;
                                o_job.status = ST_EMPTY;
                            end else begin
                                o_ra_en = 1'b1;
                                n_state = S_LEN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEN: begin
                if (!i_hold.q_full) begin
                    o_job_push = 1'b1;
                    n_rd       = ring_add(r_rd, span);
                    n_used     = (SUM_W'(r_used) >= SUM_W'(span))
                               ? r_used - USED_W'(span) : '0;
                    n_state    = S_IDLE;
                    priority if (BYTE_W'(tlen) > r_max) begin
                        o_job.status = ST_TOO_LARGE;
                        o_job.tlen   = tlen;
                    end else if (tlen == '0) begin
                        o_job.status = ST_POP_OK;
                    end else begin
                        o_job.status = ST_POP_OK;
                        o_job.stream = 1'b1;
                        o_job.start  = ring_next(r_rd);
                        o_job.tlen   = tlen;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd    <= '0;
            r_wp    <= '0;
            r_ce    <= '0;
            r_used  <= '0;
            r_owed  <= '0;
        end else begin
            r_state <= n_state;
            r_rd    <= n_rd;
            r_wp    <= n_wp;
            r_ce    <= n_ce;
            r_used  <= n_used;
            r_owed  <= n_owed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_pop) begin
            r_max <= i_in_item.max_size;
        end
    end

endmodule

/* rtl/core/lpf_queue.sv */
// Short job queue between the front and back parts of the packet FIFO.
// Depends on lpf_pkg.
module lpf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpf_pkg::t_job  i_job,
    input  logic           i_pop,
    output lpf_pkg::t_job  o_head,
    output logic           o_full,
    output logic           o_empty
);
    import lpf_pkg::*;

    t_job             r_slot [Q_DEPTH];
    logic [Q_W-1:0]   r_wr, r_rd;
    logic [Q_W:0]     r_cnt;

    function automatic logic [Q_W-1:0] q_next(input logic [Q_W-1:0] p);
        return (p == Q_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        o_head  = r_slot[r_rd];
        o_full  = (r_cnt == (Q_W + 1)'(Q_DEPTH));
        o_empty = (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_slot[r_wr] <= i_job;
                r_wr         <= q_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= q_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/lpf_back.sv */
// Back part: takes jobs from the queue, streams telegram bytes from the store
// and drives the result channel through an output register. Uses lpf_pkg.
module lpf_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lpf_pkg::t_job                i_job,
    input  logic                         i_q_empty,
    output logic                         o_pop,
    output logic                         o_busy,
    output logic                         o_rb_en,
    output logic [lpf_pkg::ADDR_W-1:0]   o_rb_addr,
    input  logic [lpf_pkg::BYTE_W-1:0]   i_rb_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output lpf_pkg::t_out_item           o_out_item
);
    import lpf_pkg::*;

    logic [ADDR_W-1:0]  r_addr;
    logic [TLEN_W-1:0]  r_rem;
    logic [TLEN_W-1:0]  r_len;
    logic               r_pend;
    logic               r_pend_last;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               out_free, move, issue, take;

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        move      = r_pend && out_free;
        issue     = (r_rem != '0) && (!r_pend || move);
        take      = (r_rem == '0) && !r_pend && !i_q_empty && (i_job.stream || out_free);
        o_pop     = take;
        o_busy    = (r_rem != '0) || r_pend;
        o_rb_en   = issue;
        o_rb_addr = r_addr;
        o_out_valid = r_out_valid;
        o_out_item  = r_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rem       <= '0;
            r_pend      <= 1'b0;
        end else begin
            if (move) begin
                r_out_valid              <= 1'b1;
                r_out_item.status        <= ST_POP_OK;
                r_out_item.out_byte      <= i_rb_data;
                r_out_item.popped_length <= LEN_W'(r_len);
                r_out_item.last          <= r_pend_last;
            end else if (take && !i_job.stream) begin
                r_out_valid              <= 1'b1;
                r_out_item.status        <= i_job.status;
                r_out_item.out_byte      <= '0;
                r_out_item.popped_length <= LEN_W'(i_job.tlen);
                r_out_item.last          <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (issue) begin
                r_addr      <= ring_next(r_addr);
                r_rem       <= r_rem - 1'b1;
                r_pend      <= 1'b1;
                r_pend_last <= (r_rem == TLEN_W'(1));
            end else if (move) begin
                r_pend <= 1'b0;
            end

            if (take && i_job.stream) begin
                r_addr <= i_job.start;
                r_rem  <= i_job.tlen;
                r_len  <= i_job.tlen;
            end
        end
    end

endmodule

/* rtl/core/length_prefixed_packet_fifo.sv */
// Top level of the length-prefixed packet FIFO: front, job queue, back, byte store.
// Depends on lpf_pkg, lpf_store, lpf_front, lpf_queue, lpf_back.
//
// channel  dir  handshake                   payload
// in       in   i_in_valid / o_in_stall     lpf_pkg::t_in_item
// out      out  o_out_valid / i_out_stall   lpf_pkg::t_out_item
//
// begin_push, push_byte and an empty pop are finished by the front without leaving S_IDLE.
// begin_push and push_byte wait until the job queue is empty and no telegram is streaming.
// A pop of a telegram reads its length byte through store port A in S_IDLE and takes it in S_LEN;
// the back loads the start address, reads port B a byte ahead and streams one byte per unstalled cycle.
// Reset clears pointers, counts and the two-entry job queue; the store is not cleared.
// A stalled result holds the back part; pops keep being taken until the job queue fills.
module length_prefixed_packet_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lpf_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lpf_pkg::t_out_item  o_out_item
);
    import lpf_pkg::*;

    t_hold              hold;
    t_job               job_in, job_head;
    logic               job_push, job_pop;
    logic               q_full, q_empty, back_busy;
    t_wr_req            wr;
    logic               ra_en, rb_en;
    logic [ADDR_W-1:0]  ra_addr, rb_addr;
    logic [BYTE_W-1:0]  ra_data, rb_data;

    always_comb begin
        hold.q_full    = q_full;
        hold.q_empty   = q_empty;
        hold.back_busy = back_busy;
    end

    lpf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_hold     (hold),
        .o_job      (job_in),
        .o_job_push (job_push),
        .o_wr       (wr),
        .o_ra_en    (ra_en),
        .o_ra_addr  (ra_addr),
        .i_ra_data  (ra_data)
    );

    lpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_head  (job_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lpf_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_ra_en   (ra_en),
        .i_ra_addr (ra_addr),
        .o_ra_data (ra_data),
        .i_rb_en   (rb_en),
        .i_rb_addr (rb_addr),
        .o_rb_data (rb_data)
    );

    lpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_q_empty   (q_empty),
        .o_pop       (job_pop),
        .o_busy      (back_busy),
        .o_rb_en     (rb_en),
        .o_rb_addr   (rb_addr),
        .i_rb_data   (rb_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* rtl/core/lpf_checker.sv */
// Port-level checks on the result channel of the packet FIFO, bound to the top level.
// Depends on lpf_pkg and length_prefixed_packet_fifo.
module lpf_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  lpf_pkg::t_out_item  o_out_item
);
    import lpf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_single_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_POP_OK)
        |-> o_out_item.last && (o_out_item.out_byte == '0))
        else $error("single result without last or with data");

    a_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_item.status == ST_ACCEPTED) || (o_out_item.status == ST_FULL)
                     || (o_out_item.status == ST_EMPTY) || (o_out_item.status == ST_PROTOCOL))
        |-> (o_out_item.popped_length == '0))
        else $error("length reported on a non-pop result");

endmodule

bind length_prefixed_packet_fifo lpf_checker u_lpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
